/* sv/ddnc_pkg.sv */
// ----------------------------------------------------------------------------
// Date and day number converter package
// Types, codes and calendar constants shared by the converter core.
// ----------------------------------------------------------------------------
package ddnc_pkg;

  typedef struct packed {
    logic        command;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [19:0] serial_in;
  } ddnc_in_t;

  typedef struct packed {
    logic [19:0] serial_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  status;
  } ddnc_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EST,
    S_Y0,
    S_Y1,
    S_Y2,
    S_Y3,
    S_Y4,
    S_STEP,
    S_WALK,
    S_EMIT
  } ddnc_state_t;

  localparam logic CMD_DATE2NUM = 1'b0;
  localparam logic CMD_NUM2DATE = 1'b1;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_YEAR_BAD  = 3'd1;
  localparam logic [2:0] STAT_MONTH_BAD = 3'd2;
  localparam logic [2:0] STAT_DAY_ZERO  = 3'd3;
  localparam logic [2:0] STAT_TOO_LARGE = 3'd4;

  localparam logic [11:0] YEAR_MIN    = 12'd1900;
  localparam logic [11:0] YEAR_MAX    = 12'd3532;
  localparam logic [11:0] EPOCH_YEAR  = 12'd1899;
  localparam logic [3:0]  EPOCH_MONTH = 4'd12;
  localparam logic [4:0]  EPOCH_DAY   = 5'd31;
  localparam logic [3:0]  MONTHS      = 4'd12;
  localparam logic [19:0] SERIAL_MAX  = 20'd596409;
  localparam logic [8:0]  LEAPS_BASE  = 9'd460;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

  // Reciprocals for division by 100 and by 365; exact over the ranges used.
  localparam logic [20:0] RECIP100 = 21'd5243;
  localparam logic [20:0] RECIP365 = 21'd1470880;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m) inside
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* sv/date_day_number_converter_core.sv */
// ----------------------------------------------------------------------------
// Date and day number converter core
// Converts a Gregorian date to a serial day count from 1899-12-31 and back,
// using one shared multiplier and a small sequencer.
// ----------------------------------------------------------------------------
// The input channel carries one request per transfer: a command bit, a date
// and a day count. The output channel returns one result per request. Both
// channels use valid and stall; a transfer happens when valid is high and
// stall is low. The block takes one request at a time and holds in_stall
// high from the transfer until the result has been loaded into the output
// register. Rejected requests, the epoch date and a day count of zero skip
// the computation and go straight to the emit state. A valid date runs the
// five states Y0 to Y4, which compute the days before the year (Y0 to Y3
// through the shared multiplier), and then the month walk, which adds one
// month length per cycle. A day count first estimates the year through the
// shared multiplier, then runs Y0 to Y4 and the step check once for the
// estimate and once more for each of j year corrections (j at most two over
// the accepted range), and then the month walk of w steps (w from 1 to 12).
// The next request can transfer in the cycle after a result is loaded.
// When the receiver stalls, the result waits in the output register and the
// block waits before loading the next one. Reset empties the output register
// and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module date_day_number_converter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ddnc_pkg::ddnc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ddnc_pkg::ddnc_out_t out_data
);
  import ddnc_pkg::*;

  ddnc_state_t state_r, state_nxt;
  logic        cmd_r, cmd_nxt;
  logic [11:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [19:0] serial_r, serial_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [3:0]  wm_r, wm_nxt;
  logic [19:0] acc_r, acc_nxt;
  logic [5:0]  q100p_r, q100p_nxt;
  logic [3:0]  q400p_r, q400p_nxt;
  logic [5:0]  q100y_r, q100y_nxt;
  logic [19:0] base_r, base_nxt;
  logic [19:0] dby_r, dby_nxt;
  logic        leap_r, leap_nxt;
  ddnc_out_t   res_r, res_nxt;
  ddnc_out_t   out_data_r, out_data_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        in_fire;
  logic        out_free;
  logic        epoch_w, year_bad_w, month_bad_w, day_zero_w;
  logic        serial_big_w, serial_zero_w;
  logic [11:0] year_m1;
  logic [19:0] mul_a;
  logic [20:0] mul_b;
  logic [40:0] mul_p;
  logic [11:0] est_year;
  logic [20:0] dby_sum;
  logic [12:0] hund_w;
  logic        mod100_w, mod400_w, leap_w;
  logic [4:0]  mlen_w, clamp_len_w, day_clamped_w;
  logic        walk_more_w, step_back_w;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign epoch_w       = (in_data.year_in == EPOCH_YEAR) && (in_data.month_in == EPOCH_MONTH) &&
                         (in_data.day_in == EPOCH_DAY);
  assign year_bad_w    = (in_data.year_in < YEAR_MIN) || (in_data.year_in > YEAR_MAX);
  assign month_bad_w   = (in_data.month_in == 4'd0) || (in_data.month_in > MONTHS);
  assign day_zero_w    = (in_data.day_in == 5'd0);
  assign serial_big_w  = (in_data.serial_in > SERIAL_MAX);
  assign serial_zero_w = (in_data.serial_in == 20'd0);

  assign year_m1 = year_r - 12'd1;

  always_comb begin
    mul_a = 20'd0;
    mul_b = 21'd0;
    unique case (state_r)
      S_Y0: begin
        mul_a = 20'(year_m1);
        mul_b = RECIP100;
      end
      S_Y1: begin
        mul_a = 20'(year_m1[11:2]);
        mul_b = RECIP100;
      end
      S_Y2: begin
        mul_a = 20'(year_r);
        mul_b = RECIP100;
      end
      S_Y3: begin
        mul_a = 20'(year_r - YEAR_MIN);
        mul_b = 21'(DAYS_PER_YEAR);
      end
      S_EST: begin
        mul_a = serial_r - 20'd1;
        mul_b = RECIP365;
      end
      default: begin
        mul_a = 20'd0;
        mul_b = 21'd0;
      end
    endcase
  end

  assign mul_p    = 41'(mul_a) * 41'(mul_b);
  assign est_year = YEAR_MIN + {1'b0, mul_p[39:29]};

  assign dby_sum = {1'b0, base_r} + 21'(year_m1[11:2]) + 21'(q400p_r)
                   - 21'(q100p_r) - 21'(LEAPS_BASE);

  assign hund_w   = 13'(q100y_r) * 13'd100;
  assign mod100_w = (hund_w == {1'b0, year_r});
  assign mod400_w = mod100_w && (q100y_r[1:0] == 2'd0);
  assign leap_w   = (year_r[1:0] == 2'd0) && (!mod100_w || mod400_w);

  assign mlen_w        = month_len(wm_r, leap_r);
  assign clamp_len_w   = month_len(month_r, leap_r);
  assign day_clamped_w = (day_r > clamp_len_w) ? clamp_len_w : day_r;

  assign walk_more_w = (cmd_r == CMD_DATE2NUM) ? (wm_r < month_r) :
                       ((wm_r < MONTHS) && (acc_r > 20'(mlen_w)));
  assign step_back_w = (cnt_r < 3'd4) && (year_r > YEAR_MIN) && (dby_r >= serial_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.command == CMD_DATE2NUM) begin
            if (epoch_w || year_bad_w || month_bad_w || day_zero_w) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_Y0;
            end
          end else begin
            if (serial_big_w || serial_zero_w) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_EST;
            end
          end
        end
      end
      S_EST:  state_nxt = S_Y0;
      S_Y0:   state_nxt = S_Y1;
      S_Y1:   state_nxt = S_Y2;
      S_Y2:   state_nxt = S_Y3;
      S_Y3:   state_nxt = S_Y4;
      S_Y4:   state_nxt = (cmd_r == CMD_DATE2NUM) ? S_WALK : S_STEP;
      S_STEP: state_nxt = step_back_w ? S_Y0 : S_WALK;
      S_WALK: state_nxt = walk_more_w ? S_WALK : S_EMIT;
      S_EMIT: state_nxt = out_free ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt    = cmd_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    serial_nxt = serial_r;
    cnt_nxt    = cnt_r;
    wm_nxt     = wm_r;
    acc_nxt    = acc_r;
    q100p_nxt  = q100p_r;
    q400p_nxt  = q400p_r;
    q100y_nxt  = q100y_r;
    base_nxt   = base_r;
    dby_nxt    = dby_r;
    leap_nxt   = leap_r;
    res_nxt    = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt    = in_data.command;
          year_nxt   = in_data.year_in;
          month_nxt  = in_data.month_in;
          day_nxt    = in_data.day_in;
          serial_nxt = in_data.serial_in;
          cnt_nxt    = 3'd0;
          res_nxt    = '{serial_out: 20'd0, year_out: 12'd0, month_out: 4'd0,
                         day_out: 5'd0, status: STAT_OK};
          if (in_data.command == CMD_DATE2NUM) begin
            if (epoch_w) begin
              res_nxt.year_out  = EPOCH_YEAR;
              res_nxt.month_out = EPOCH_MONTH;
              res_nxt.day_out   = EPOCH_DAY;
            end else if (year_bad_w) begin
              res_nxt.status = STAT_YEAR_BAD;
            end else if (month_bad_w) begin
              res_nxt.status = STAT_MONTH_BAD;
            end else if (day_zero_w) begin
              res_nxt.status = STAT_DAY_ZERO;
            end
          end else begin
            if (serial_big_w) begin
              res_nxt.status = STAT_TOO_LARGE;
            end else if (serial_zero_w) begin
              res_nxt.year_out  = EPOCH_YEAR;
              res_nxt.month_out = EPOCH_MONTH;
              res_nxt.day_out   = EPOCH_DAY;
            end
          end
        end
      end
      S_EST: begin
        year_nxt = est_year;
      end
      S_Y0: begin
        q100p_nxt = mul_p[24:19];
      end
      S_Y1: begin
        q400p_nxt = mul_p[22:19];
      end
      S_Y2: begin
        q100y_nxt = mul_p[24:19];
      end
      S_Y3: begin
        base_nxt = mul_p[19:0];
        leap_nxt = leap_w;
      end
      S_Y4: begin
        dby_nxt = dby_sum[19:0];
        acc_nxt = dby_sum[19:0];
        wm_nxt  = 4'd1;
      end
      S_STEP: begin
        if (step_back_w) begin
          year_nxt = year_r - 12'd1;
          cnt_nxt  = cnt_r + 3'd1;
        end else begin
          acc_nxt = serial_r - dby_r;
          wm_nxt  = 4'd1;
        end
      end
      S_WALK: begin
        if (walk_more_w) begin
          wm_nxt  = wm_r + 4'd1;
          acc_nxt = (cmd_r == CMD_DATE2NUM) ? (acc_r + 20'(mlen_w)) : (acc_r - 20'(mlen_w));
        end else if (cmd_r == CMD_DATE2NUM) begin
          res_nxt = '{serial_out: acc_r + 20'(day_clamped_w), year_out: year_r,
                      month_out: month_r, day_out: day_clamped_w, status: STAT_OK};
        end else begin
          res_nxt = '{serial_out: serial_r, year_out: year_r, month_out: wm_r,
                      day_out: acc_r[4:0], status: STAT_OK};
        end
      end
      S_EMIT: begin
        res_nxt = res_r;
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if ((state_r == S_EMIT) && out_free) begin
      out_data_nxt  = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    year_r     <= year_nxt;
    month_r    <= month_nxt;
    day_r      <= day_nxt;
    serial_r   <= serial_nxt;
    cnt_r      <= cnt_nxt;
    wm_r       <= wm_nxt;
    acc_r      <= acc_nxt;
    q100p_r    <= q100p_nxt;
    q400p_r    <= q400p_nxt;
    q100y_r    <= q100y_nxt;
    base_r     <= base_nxt;
    dby_r      <= dby_nxt;
    leap_r     <= leap_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_fire_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("An accepted transfer did not start the sequencer.");

  a_walk_month: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ((wm_r >= 4'd1) && (wm_r <= MONTHS)))
    else $error("The month walk left the range of months.");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != STAT_OK)) |->
      ((out_data_r.serial_out == 20'd0) && (out_data_r.year_out == 12'd0) &&
       (out_data_r.month_out == 4'd0) && (out_data_r.day_out == 5'd0)))
    else $error("An error result carries nonzero fields.");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (cnt_r <= 3'd4))
    else $error("The year correction ran past its bound.");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && out_free) |=> out_valid_r)
    else $error("A finished result was not loaded into the output register.");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the date and day number converter core
// Sends dates and day counts through the input channel and checks every
// result against a predictor of the calendar arithmetic kept in the bench.
// Directed corner cases come first: the epoch date, range limits, clamped
// days and leap rules. Random requests with random gaps and stalls follow.
// ----------------------------------------------------------------------------
module testbench;
  import ddnc_pkg::*;

  typedef struct {
    ddnc_in_t    req;
    int unsigned gap;
    bit          drain;
  } pending_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  ddnc_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  ddnc_out_t out_data;

  pending_t    pending_requests[$];
  ddnc_out_t   awaited_results[$];
  int unsigned item_total;
  int unsigned sent_cnt;
  int unsigned result_cnt;
  int unsigned fail_cnt;
  int unsigned date_cnt;
  int unsigned count_cnt;
  int unsigned err_cnt;
  int unsigned gap_left;
  bit          gap_loaded;
  int unsigned stall_left;
  logic        in_taken;

  date_day_number_converter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned cal_is_leap(input int unsigned y);
    if (y % 400 == 0) return 1;
    if (y % 100 == 0) return 0;
    if (y % 4 == 0) return 1;
    return 0;
  endfunction

  function automatic int unsigned cal_month_days(input int unsigned y, input int unsigned m);
    case (m)
      2:          return 28 + cal_is_leap(y);
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic int unsigned cal_days_before_year(input int unsigned y);
    int unsigned p;
    p = y - 1;
    return (y - 1900) * 365 + p / 4 - p / 100 + p / 400 - 460;
  endfunction

  function automatic ddnc_out_t convert_request(input ddnc_in_t rq);
    ddnc_out_t   r;
    int unsigned y, m, d, lim, total, s, rem, k;
    r = '0;
    if (rq.command == CMD_DATE2NUM) begin
      y = rq.year_in;
      m = rq.month_in;
      d = rq.day_in;
      if (y == EPOCH_YEAR && m == EPOCH_MONTH && d == EPOCH_DAY) begin
        r.year_out  = 12'(y);
        r.month_out = 4'(m);
        r.day_out   = 5'(d);
        r.status    = STAT_OK;
      end else if (y < YEAR_MIN || y > YEAR_MAX) begin
        r.status = STAT_YEAR_BAD;
      end else if (m < 1 || m > MONTHS) begin
        r.status = STAT_MONTH_BAD;
      end else begin
        lim = cal_month_days(y, m);
        if (d > lim) d = lim;
        if (d < 1) begin
          r.status = STAT_DAY_ZERO;
        end else begin
          total = cal_days_before_year(y);
          for (k = 1; k < m; k++) total += cal_month_days(y, k);
          total += d;
          r.serial_out = 20'(total);
          r.year_out   = 12'(y);
          r.month_out  = 4'(m);
          r.day_out    = 5'(d);
          r.status     = STAT_OK;
        end
      end
    end else begin
      s = rq.serial_in;
      if (s > SERIAL_MAX) begin
        r.status = STAT_TOO_LARGE;
      end else if (s == 0) begin
        r.year_out  = EPOCH_YEAR;
        r.month_out = EPOCH_MONTH;
        r.day_out   = EPOCH_DAY;
        r.status    = STAT_OK;
      end else begin
        y = YEAR_MIN + (s - 1) / 365;
        k = 0;
        while (k < 4 && y > YEAR_MIN && cal_days_before_year(y) >= s) begin
          y--;
          k++;
        end
        rem = s - cal_days_before_year(y);
        m = 1;
        k = 0;
        while (k < 11 && rem > cal_month_days(y, m)) begin
          rem -= cal_month_days(y, m);
          m++;
          k++;
        end
        r.serial_out = 20'(s);
        r.year_out   = 12'(y);
        r.month_out  = 4'(m);
        r.day_out    = 5'(rem);
        r.status     = STAT_OK;
      end
    end
    return r;
  endfunction

  task automatic add_item(input ddnc_in_t rq);
    pending_t    p;
    int unsigned idx;
    idx = pending_requests.size();
    p.req   = rq;
    p.gap   = ((idx / 100) % 4 == 3) ? 0 : $urandom_range(0, 10);
    p.drain = (idx % 250 == 249);
    pending_requests.push_back(p);
  endtask

  task automatic add_date(input int unsigned y, input int unsigned m, input int unsigned d);
    ddnc_in_t rq;
    rq.command   = CMD_DATE2NUM;
    rq.year_in   = 12'(y);
    rq.month_in  = 4'(m);
    rq.day_in    = 5'(d);
    rq.serial_in = 20'($urandom);
    add_item(rq);
  endtask

  task automatic add_serial(input int unsigned s);
    ddnc_in_t rq;
    rq.command   = CMD_NUM2DATE;
    rq.year_in   = 12'($urandom);
    rq.month_in  = 4'($urandom);
    rq.day_in    = 5'($urandom);
    rq.serial_in = 20'(s);
    add_item(rq);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Input side: one transfer at a time, each preceded by its own gap.
  always @(negedge clk) begin
    logic nxt_valid;
    nxt_valid = in_valid;
    if (rst_n) begin
      if (in_valid && in_taken) begin
        nxt_valid = 1'b0;
        sent_cnt++;
      end
      if (!nxt_valid && pending_requests.size() > 0) begin
        if (!gap_loaded) begin
          gap_left   = pending_requests[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending_requests[0].drain || awaited_results.size() == 0) begin
          in_data   <= pending_requests[0].req;
          nxt_valid  = 1'b1;
          void'(pending_requests.pop_front());
          gap_loaded = 1'b0;
        end
      end
    end
    in_valid <= nxt_valid;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    ddnc_out_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        want = convert_request(in_data);
        awaited_results.push_back(want);
        if (in_data.command == CMD_DATE2NUM) date_cnt++;
        else count_cnt++;
        if (want.status != STAT_OK) err_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_cnt++;
        end else begin
          want = awaited_results.pop_front();
          check_field("serial_out", want.serial_out, out_data.serial_out);
          check_field("year_out", want.year_out, out_data.year_out);
          check_field("month_out", want.month_out, out_data.month_out);
          check_field("day_out", want.day_out, out_data.day_out);
          check_field("status", want.status, out_data.status);
        end
        result_cnt++;
        stall_left <= ((result_cnt / 100) % 4 == 3) ? 0 : $urandom_range(0, 10);
      end
    end
  end

  initial begin
    int unsigned i, sel, y;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    sent_cnt   = 0;
    result_cnt = 0;
    fail_cnt   = 0;
    date_cnt   = 0;
    count_cnt  = 0;
    err_cnt    = 0;
    gap_left   = 0;
    gap_loaded = 1'b0;
    stall_left = 0;

    add_date(1899, 12, 31);
    add_date(1899, 12, 30);
    add_date(1899, 1, 1);
    add_date(1900, 1, 1);
    add_date(1900, 2, 29);
    add_date(2000, 2, 31);
    add_date(2004, 2, 30);
    add_date(2100, 2, 29);
    add_date(3532, 12, 31);
    add_date(3532, 11, 29);
    add_date(3533, 1, 1);
    add_date(0, 0, 0);
    add_date(4095, 15, 31);
    add_date(2024, 0, 15);
    add_date(2024, 13, 1);
    add_date(2024, 15, 31);
    add_date(2024, 6, 0);
    add_date(1900, 0, 0);
    add_serial(0);
    add_serial(1);
    add_serial(60);
    add_serial(36525);
    add_serial(596409);
    add_serial(596410);
    add_serial(596441);
    add_serial(1048575);

    for (i = 0; i < 1600; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        add_date($urandom_range(1900, 3532), $urandom_range(1, 12), $urandom_range(0, 31));
      end else if (sel < 40) begin
        y = $urandom_range(19, 35) * 100 + $urandom_range(0, 4);
        add_date(y, $urandom_range(1, 12), $urandom_range(27, 31));
      end else if (sel < 65) begin
        add_serial($urandom_range(1, 596409));
      end else if (sel < 80) begin
        y = $urandom_range(1901, 3532);
        add_serial(cal_days_before_year(y) + $urandom_range(0, 2) - 1);
      end else if (sel < 90) begin
        add_date($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31));
      end else begin
        add_serial($urandom_range(0, 1048575));
      end
    end
    item_total = pending_requests.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (sent_cnt < item_total || awaited_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      fail_cnt++;
    end
    $display("Converted %0d requests: %0d dates to day counts, %0d day counts to dates.",
             result_cnt, date_cnt, count_cnt);
    $display("%0d requests were rejected with an error status; %0d mismatches found.",
             err_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* date_day_number_converter_core.f */
sv/ddnc_pkg.sv
sv/date_day_number_converter_core.sv
bench/testbench.sv
